>>> design/smwa_pkg.sv
// ----------------------------------------------------------------------------
// smwa_pkg
// Shared types and constants for the sign-magnitude word ALU.
// ----------------------------------------------------------------------------
package smwa_pkg;

    localparam int WORD_W  = 31;
    localparam int MAG_W   = 30;
    localparam int DMAG_W  = 60;
    localparam int CNT_W   = 12;
    localparam int BYTE_W  = 6;
    localparam int NBYTES2 = 10;
    localparam int OP_W    = 3;
    localparam int DIV_STAGES = 30;
    localparam int QDEPTH_DEFAULT = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_MUL = 3'd1,
        OP_DIV = 3'd2,
        OP_SLA = 3'd3,
        OP_SRA = 3'd4,
        OP_SLC = 3'd5,
        OP_NO6 = 3'd6,
        OP_NO7 = 3'd7
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
        logic [WORD_W-1:0] divisor_word;
        logic [CNT_W-1:0]  shift_count;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] high_result;
        logic [WORD_W-1:0] low_result;
        logic              exception_flag;
    } t_out_item;

    // Classified item handed from front to back.
    typedef struct packed {
        t_op               op;
        logic              s1;
        logic              s2;
        logic              sd;
        logic [MAG_W-1:0]  m1;
        logic [MAG_W-1:0]  m2;
        logic [MAG_W-1:0]  md;
        logic              div_ovf;
        logic [3:0]        bytes;   // byte shift 0..9
        logic              clear;   // non-circular count of 10 or more
    } t_work;

endpackage

>>> design/smwa_front.sv
// ----------------------------------------------------------------------------
// smwa_front
// Accepts items, classifies them and queues them for the execution pipe.
// ----------------------------------------------------------------------------
module smwa_front #(
    parameter int QDEPTH = smwa_pkg::QDEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  smwa_pkg::t_in_item i_item,
    output logic               o_valid,
    input  logic               i_take,
    output smwa_pkg::t_work    o_work
);
    import smwa_pkg::*;

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_work           r_mem [QDEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    t_work           w_cls;
    logic [3:0]      w_mod;
    logic            w_push, w_pop;

    // count mod 10 for the circular shift: 12-bit value, small reciprocal
    function automatic logic [3:0] mod10(input logic [CNT_W-1:0] c);
        logic [CNT_W+11:0] q;
        logic [CNT_W+3:0] r;
        begin
            q = ({12'd0, c} * 24'd3277) >> 15;   // exact floor(c/10) for c < 4096
            r = {4'd0, c} - q[CNT_W+3:0] * 16'd10;
            mod10 = r[3:0];
        end
    endfunction

    assign w_mod = mod10(i_item.shift_count);

    always_comb begin
        w_cls.op   = t_op'(i_item.operation);
        w_cls.s1   = i_item.first_word[MAG_W];
        w_cls.s2   = i_item.second_word[MAG_W];
        w_cls.sd   = i_item.divisor_word[MAG_W];
        w_cls.m1   = i_item.first_word[MAG_W-1:0];
        w_cls.m2   = i_item.second_word[MAG_W-1:0];
        w_cls.md   = i_item.divisor_word[MAG_W-1:0];
        w_cls.div_ovf = (i_item.divisor_word[MAG_W-1:0] <= i_item.first_word[MAG_W-1:0]);
        w_cls.clear = 1'b0;
        w_cls.bytes = 4'd0;
        if (t_op'(i_item.operation) == OP_SLC) begin
            w_cls.bytes = w_mod;
        end else if (i_item.shift_count >= CNT_W'(NBYTES2)) begin
            w_cls.clear = 1'b1;
        end else begin
            w_cls.bytes = i_item.shift_count[3:0];
        end
    end

    assign full    = (r_cnt == (AW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_work  = r_mem[r_rp];
    assign w_push  = push && !full;
    assign w_pop   = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == AW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule

>>> design/smwa_back.sv
// ----------------------------------------------------------------------------
// smwa_back
// Execution pipe: add/multiply/shift/divide with a one-bit-per-stage divider,
// then a result queue with a registered output that never overflows thanks
// to credit counting.
// ----------------------------------------------------------------------------
module smwa_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_take,
    input  smwa_pkg::t_work     i_work,
    output logic                empty,
    input  logic                pop,
    output smwa_pkg::t_out_item o_item
);
    import smwa_pkg::*;

    localparam int NST = DIV_STAGES + 2;       // stage 0 compute, 1..30 divide, last format
    localparam int ODEPTH = NST + 2;
    localparam int OAW = $clog2(ODEPTH);

    // pipeline payload
    logic              r_v   [NST];
    t_op               r_op  [NST];
    logic              r_s1  [NST];
    logic              r_sq  [NST];
    logic              r_ovf [NST];
    logic [MAG_W-1:0]  r_hi  [NST];
    logic [MAG_W-1:0]  r_lo  [NST];
    logic [MAG_W:0]    r_rem [NST];   // partial remainder (fits 31 bits)
    logic [MAG_W-1:0]  r_md  [NST];
    logic              r_flag[NST];

    t_out_item         r_oq [ODEPTH];
    t_out_item         r_out;         // head of the result queue
    logic              r_ov;
    logic [OAW-1:0]    r_owp, r_orp;
    logic [OAW:0]      r_ocnt, r_mcnt, r_infl;
    logic              w_in, w_opop, w_done;
    logic              w_oload, w_mwr, w_mrd;

    // stage 0 combinational results
    logic [MAG_W:0]    w_sum;
    logic [DMAG_W-1:0] w_prod, w_dmag, w_sh;
    logic [5:0]        w_bits;
    logic [MAG_W-1:0]  w_hi0, w_lo0;
    logic              w_flag0;
    t_out_item         w_res;

    // Admission: pipeline + queue slots are credited so output can stall freely.
    assign o_take = i_valid && ((r_infl + r_ocnt) < (OAW+1)'(ODEPTH));
    assign w_in   = o_take;
    assign empty  = !r_ov;
    assign w_opop = pop && r_ov;
    assign w_done = r_v[NST-1];
    assign o_item = r_out;

    // head register refills from memory, or straight from the pipe when memory is empty
    assign w_oload = !r_ov || w_opop;
    assign w_mrd   = w_oload && (r_mcnt != '0);
    assign w_mwr   = w_done && !(w_oload && (r_mcnt == '0));

    always_comb begin
        w_sum   = {1'b0, i_work.m1} + {1'b0, i_work.m2};
        w_prod  = DMAG_W'(i_work.m1) * DMAG_W'(i_work.m2);
        w_dmag  = {i_work.m1, i_work.m2};
        w_bits  = 6'(i_work.bytes) * 6'(BYTE_W);
        w_hi0   = '0;
        w_lo0   = '0;
        w_flag0 = 1'b0;
        w_sh    = '0;
        case (i_work.op)
            OP_ADD: begin
                if (i_work.s1 == i_work.s2) begin
                    w_flag0 = w_sum[MAG_W];
                    w_hi0   = MAG_W'(w_sum[MAG_W]);
                    w_lo0   = w_sum[MAG_W-1:0];
                end else if (i_work.m1 >= i_work.m2) begin
                    w_lo0 = i_work.m1 - i_work.m2;
                end else begin
                    w_lo0 = i_work.m2 - i_work.m1;
                end
            end
            OP_MUL: begin
                w_hi0 = w_prod[DMAG_W-1:MAG_W];
                w_lo0 = w_prod[MAG_W-1:0];
            end
            OP_SLA, OP_SRA, OP_SLC: begin
                if (!i_work.clear) begin
                    if (i_work.op == OP_SRA) w_sh = w_dmag >> w_bits;
                    else if (i_work.op == OP_SLA) w_sh = w_dmag << w_bits;
                    else w_sh = (w_dmag << w_bits) | (w_dmag >> (6'd60 - w_bits));
                end
                w_hi0 = w_sh[DMAG_W-1:MAG_W];
                w_lo0 = w_sh[MAG_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // stage 0 register; divide shifts m2 through r_lo as quotient collects
    always_ff @(posedge i_clk) begin
        r_op[0]  <= i_work.op;
        r_ovf[0] <= i_work.div_ovf;
        r_md[0]  <= i_work.md;
        r_rem[0] <= {1'b0, i_work.m1};
        if (i_work.op == OP_DIV) begin
            r_hi[0]   <= '0;
            r_lo[0]   <= i_work.m2;
            r_flag[0] <= i_work.div_ovf;
            r_s1[0]   <= i_work.s1;
            r_sq[0]   <= i_work.s1 ^ i_work.sd;
        end else begin
            r_hi[0]   <= w_hi0;
            r_lo[0]   <= w_lo0;
            r_flag[0] <= w_flag0;
            if (i_work.op == OP_ADD) begin
                r_s1[0] <= (i_work.s1 == i_work.s2 || i_work.m1 >= i_work.m2)
                           ? i_work.s1 : i_work.s2;
                r_sq[0] <= (i_work.s1 == i_work.s2 || i_work.m1 >= i_work.m2)
                           ? i_work.s1 : i_work.s2;
            end else if (i_work.op == OP_MUL) begin
                r_s1[0] <= i_work.s1 ^ i_work.s2;
                r_sq[0] <= i_work.s1 ^ i_work.s2;
            end else if (i_work.op == OP_NO6 || i_work.op == OP_NO7) begin
                r_s1[0] <= 1'b0;
                r_sq[0] <= 1'b0;
            end else begin
                r_s1[0] <= i_work.s2;   // low word sign
                r_sq[0] <= i_work.s1;   // high word sign
            end
        end
    end

    // restoring divide, one quotient bit per stage; other ops pass through
    for (genvar g = 1; g < NST; g++) begin : g_st
        if (g <= DIV_STAGES) begin : g_div
            logic [MAG_W+1:0] w_tr;
            logic [MAG_W+1:0] w_df;
            assign w_tr = {r_rem[g-1], r_lo[g-1][MAG_W-1]};
            assign w_df = w_tr - {2'b0, r_md[g-1]};
            always_ff @(posedge i_clk) begin
                r_op[g] <= r_op[g-1]; r_ovf[g] <= r_ovf[g-1]; r_md[g] <= r_md[g-1];
                r_s1[g] <= r_s1[g-1]; r_sq[g] <= r_sq[g-1]; r_flag[g] <= r_flag[g-1];
                if (r_op[g-1] == OP_DIV) begin
                    r_lo[g] <= {r_lo[g-1][MAG_W-2:0], 1'b0};
                    if (!w_df[MAG_W+1]) begin
                        r_rem[g] <= w_df[MAG_W:0];
                        r_hi[g]  <= {r_hi[g-1][MAG_W-2:0], 1'b1};
                    end else begin
                        r_rem[g] <= w_tr[MAG_W:0];
                        r_hi[g]  <= {r_hi[g-1][MAG_W-2:0], 1'b0};
                    end
                end else begin
                    r_lo[g] <= r_lo[g-1]; r_hi[g] <= r_hi[g-1]; r_rem[g] <= r_rem[g-1];
                end
            end
        end else begin : g_fmt
            always_ff @(posedge i_clk) begin
                r_op[g] <= r_op[g-1]; r_ovf[g] <= r_ovf[g-1]; r_md[g] <= r_md[g-1];
                r_s1[g] <= r_s1[g-1]; r_sq[g] <= r_sq[g-1]; r_flag[g] <= r_flag[g-1];
                r_rem[g] <= r_rem[g-1];
                r_hi[g]  <= r_hi[g-1];
                r_lo[g]  <= (r_op[g-1] == OP_DIV) ? r_rem[g-1][MAG_W-1:0] : r_lo[g-1];
            end
        end
    end

    // output formatting
    always_comb begin
        w_res.exception_flag = r_flag[NST-1];
        if (r_op[NST-1] == OP_DIV && r_ovf[NST-1]) begin
            w_res.high_result = '0;
            w_res.low_result  = '0;
        end else if (r_op[NST-1] == OP_ADD) begin
            w_res.high_result = (r_hi[NST-1] != '0) ? {r_sq[NST-1], r_hi[NST-1]} : '0;
            w_res.low_result  = {r_s1[NST-1], r_lo[NST-1]};
        end else if (r_op[NST-1] == OP_DIV) begin
            w_res.high_result = {r_sq[NST-1], r_hi[NST-1]};
            w_res.low_result  = {r_s1[NST-1], r_lo[NST-1]};
        end else begin
            w_res.high_result = {r_sq[NST-1], r_hi[NST-1]};
            w_res.low_result  = {r_s1[NST-1], r_lo[NST-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mwr) r_oq[r_owp] <= w_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_mrd) begin
            r_out <= r_oq[r_orp];
        end else if (w_oload && w_done) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_v[k] <= 1'b0;
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
            r_mcnt <= '0;
            r_infl <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_v[0] <= w_in;
            for (int k = 1; k < NST; k++) r_v[k] <= r_v[k-1];
            if (w_mwr) r_owp <= (r_owp == OAW'(ODEPTH-1)) ? '0 : r_owp + 1'b1;
            if (w_mrd) r_orp <= (r_orp == OAW'(ODEPTH-1)) ? '0 : r_orp + 1'b1;
            if (w_oload) r_ov <= w_mrd || w_done;
            r_mcnt <= r_mcnt + (OAW+1)'(w_mwr) - (OAW+1)'(w_mrd);
            r_ocnt <= r_ocnt + (OAW+1)'(w_done) - (OAW+1)'(w_opop);
            r_infl <= r_infl + (OAW+1)'(w_in) - (OAW+1)'(w_done);
        end
    end
endmodule

>>> design/sign_magnitude_word_alu.sv
// ----------------------------------------------------------------------------
// sign_magnitude_word_alu
// 31-bit sign-magnitude ALU: add with carry, multiply, double-word divide,
// byte shifts of the A:X pair.
// ----------------------------------------------------------------------------
//  channel | handshake        | payload
//  --------+------------------+---------------------------------------
//  input   | i_push / o_full  | i_in  (operation, words, shift count)
//  result  | o_empty / i_pop  | o_out (high, low, exception flag)
//
// One transaction per cycle sustained while results are popped as they
// arrive. A result passes, for every operation, through the classification
// queue, 1 compute stage, 30 divide stages (one quotient bit each), 1 format
// stage and the registered head of the result queue before it shows on o_out.
// Synchronous active-low reset empties both queues and the pipeline.
// A stalled result side fills the result queue; credits stop issue from the
// front queue, which then asserts full.
// ----------------------------------------------------------------------------
module sign_magnitude_word_alu #(
    parameter int QDEPTH = smwa_pkg::QDEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  smwa_pkg::t_in_item  i_in,
    output logic                o_empty,
    input  logic                i_pop,
    output smwa_pkg::t_out_item o_out
);
    import smwa_pkg::*;

    logic  w_valid, w_take;
    t_work w_work;

    smwa_front #(.QDEPTH(QDEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(i_push), .full(o_full), .i_item(i_in),
        .o_valid(w_valid), .i_take(w_take), .o_work(w_work)
    );

    smwa_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_valid), .o_take(w_take), .i_work(w_work),
        .empty(o_empty), .pop(i_pop), .o_item(o_out)
    );
endmodule
